// ----- hw/rtl/ucs_pkg.sv -----
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types and constants of the UTF-8 control sanitizer.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int JobBytes  = 6;
  localparam int QueueDepth = 2;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] TAB        = 8'h09;
  localparam logic [7:0] DEL        = 8'h7F;
  localparam logic [7:0] C1_MAX     = 8'h9F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD_END   = 8'hF5;
  localparam logic [7:0] PIC_B0     = 8'hE2;
  localparam logic [7:0] PIC_B1     = 8'h90;
  localparam logic [7:0] PIC_BASE   = 8'h80;
  localparam logic [7:0] PIC_DEL    = 8'hA1;
  localparam logic [7:0] REPL_B0    = 8'hEF;
  localparam logic [7:0] REPL_B1    = 8'hBF;
  localparam logic [7:0] REPL_B2    = 8'hBD;

  // sequence length codes of a lead byte
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // one input's worth of output words, bytes[0] first
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [2:0]               count;
  } ucs_job_t;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] r;
    if (c < 8'h80)           r = LEN_ASCII;
    else if (c < LEAD2_MIN)  r = LEN_NONE;
    else if (c < LEAD3_MIN)  r = LEN_TWO;
    else if (c < LEAD4_MIN)  r = LEN_THREE;
    else if (c < LEAD_END)   r = LEN_FOUR;
    else                     r = LEN_NONE;
    return r;
  endfunction

endpackage

// ----- hw/rtl/ucs_front.sv -----
// ----------------------------------------------------------------------------
// ucs_front
// Takes input words, tracks held multi-byte stumps and builds output jobs.
// ----------------------------------------------------------------------------
module ucs_front import ucs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [7:0] in_byte,
  input  logic     in_end,
  input  logic     q_full,
  output logic     in_ready,
  output logic     push,
  output ucs_job_t push_job
);

  logic [7:0] held_bytes [3];
  logic [1:0] held_count, held_count_next;
  logic [2:0] needed_length, needed_length_next;
  logic       held_we;
  logic [1:0] held_wa;

  logic       accept;
  logic [2:0] want;
  logic [7:0] fr [3];
  logic [2:0] fr_n;
  logic       fr_hold;
  logic       is_cont;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = in_byte[7:6] == 2'b10;
  assign want     = lead_len(in_byte);

  // handling of a byte with nothing held
  always_comb begin
    fr[0]   = in_byte;
    fr[1]   = PIC_B1;
    fr[2]   = PIC_BASE;
    fr_n    = 3'd1;
    fr_hold = 1'b0;
    if (want == LEN_ASCII) begin
      if ((in_byte < CTRL_LIMIT && in_byte != TAB) || in_byte == DEL) begin
        fr[0] = PIC_B0;
        fr[1] = PIC_B1;
        fr[2] = (in_byte == DEL) ? PIC_DEL : (PIC_BASE | in_byte);
        fr_n  = 3'd3;
      end
    end else if (want == LEN_NONE) begin
      if (in_byte <= C1_MAX) begin
        fr[0] = REPL_B0;
        fr[1] = REPL_B1;
        fr[2] = REPL_B2;
        fr_n  = 3'd3;
      end
    end else if (in_end) begin
      // lead on the last word: stump at once
      fr[0] = REPL_B0;
      fr[1] = REPL_B1;
      fr[2] = REPL_B2;
      fr_n  = 3'd3;
    end else begin
      fr_n    = 3'd0;
      fr_hold = 1'b1;
    end
  end

  always_comb begin
    push_job            = '0;
    held_count_next     = held_count;
    needed_length_next  = needed_length;
    held_we             = 1'b0;
    held_wa             = 2'd0;
    if (held_count != 2'd0) begin
      if (is_cont) begin
        if ({1'b0, held_count} + 3'd1 >= needed_length) begin
          if (held_bytes[0] == LEAD2_MIN && in_byte <= C1_MAX) begin
            push_job.bytes[0] = REPL_B0;
            push_job.bytes[1] = REPL_B1;
            push_job.bytes[2] = REPL_B2;
            push_job.count    = 3'd3;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (k < int'(held_count)) push_job.bytes[k] = held_bytes[k];
            end
            push_job.bytes[{1'b0, held_count}] = in_byte;
            push_job.count = {1'b0, held_count} + 3'd1;
          end
          held_count_next    = 2'd0;
          needed_length_next = 3'd0;
        end else begin
          held_we = 1'b1;
          held_wa = held_count;
          if (in_end) begin
            push_job.bytes[0]  = REPL_B0;
            push_job.bytes[1]  = REPL_B1;
            push_job.bytes[2]  = REPL_B2;
            push_job.count     = 3'd3;
            held_count_next    = 2'd0;
            needed_length_next = 3'd0;
          end else begin
            held_count_next = held_count + 2'd1;
          end
        end
      end else begin
        // stump cut short, then the new byte as if nothing were held
        push_job.bytes[0] = REPL_B0;
        push_job.bytes[1] = REPL_B1;
        push_job.bytes[2] = REPL_B2;
        push_job.bytes[3] = fr[0];
        push_job.bytes[4] = fr[1];
        push_job.bytes[5] = fr[2];
        push_job.count    = 3'd3 + fr_n;
        held_we           = fr_hold;
        held_wa           = 2'd0;
        held_count_next    = fr_hold ? 2'd1 : 2'd0;
        needed_length_next = fr_hold ? want : 3'd0;
      end
    end else begin
      push_job.bytes[0]  = fr[0];
      push_job.bytes[1]  = fr[1];
      push_job.bytes[2]  = fr[2];
      push_job.count     = fr_n;
      held_we            = fr_hold;
      held_wa            = 2'd0;
      held_count_next    = fr_hold ? 2'd1 : 2'd0;
      needed_length_next = fr_hold ? want : 3'd0;
    end
  end

  assign push = accept && (push_job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_length <= 3'd0;
    end else if (accept) begin
      held_count    <= held_count_next;
      needed_length <= needed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) held_bytes[held_wa] <= in_byte;
  end

  a_hold_short: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> needed_length > {1'b0, held_count})
    else $error("held stump not shorter than its sequence");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full && push_job.count <= 3'd6)
    else $error("job pushed into full queue or too long");

endmodule

// ----- hw/rtl/ucs_queue.sv -----
// ----------------------------------------------------------------------------
// ucs_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ucs_queue import ucs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ucs_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output ucs_job_t head
);

  ucs_job_t   mem [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = fill == 2'(QueueDepth);
  assign not_empty = fill != 2'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/ucs_back.sv -----
// ----------------------------------------------------------------------------
// ucs_back
// Serialises queued jobs into output words, one byte per beat.
// ----------------------------------------------------------------------------
module ucs_back import ucs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  ucs_job_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [2:0] idx;
  logic       beat;

  assign out_valid = q_valid;
  assign out_byte  = head.bytes[idx];
  assign out_last  = idx == head.count - 3'd1;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (beat) begin
      idx <= out_last ? 3'd0 : idx + 3'd1;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx < head.count && head.count != 3'd0)
    else $error("byte index beyond job length");

endmodule

// ----- hw/rtl/utf8_control_sanitizer_top.sv -----
// ----------------------------------------------------------------------------
// utf8_control_sanitizer_top
// Each input's job is registered in the queue before its first output byte appears.
// Throughput: one input word per cycle while each gives at most one byte
//   and the output is ready; a word that expands to more than one byte holds
//   the output while its bytes are sent, and the two-job queue between front and back absorbs the difference.
// Reset: synchronous; clears the held stump and empties the queue.
// ----------------------------------------------------------------------------
module utf8_control_sanitizer_top import ucs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_run
);

  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  ucs_job_t push_job;
  ucs_job_t head;

  ucs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .push_job (push_job)
  );

  ucs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  ucs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
